@@ rtl/asbg_pkg.sv @@
// ----------------------------------------------------------------------------
// Alarm snapshot burst gate package
// Shared types and constants for the per-channel alarm snapshot gate.
// ----------------------------------------------------------------------------
package asbg_pkg;

   localparam int CH_W    = 5;
   localparam int TYPE_W  = 32;
   localparam int TS_W    = 63;
   localparam int COUNT_W = 8;
   localparam int IVAL_W  = 16;
   localparam int SPAN_W  = 5;
   localparam int US_W    = 20;
   localparam int THR_W   = IVAL_W + US_W;

   localparam logic [US_W-1:0]   US_PER_S       = 20'd1000000;
   localparam logic [SPAN_W-1:0] SPAN_CAP       = 5'd20;
   localparam logic [COUNT_W-1:0] RESET_BURST   = 8'd3;
   localparam logic [IVAL_W-1:0] RESET_INTERVAL = 16'd2;

   // Register indexes of the configuration port.
   localparam logic CSR_BURST_COUNT  = 1'b0;
   localparam logic CSR_MIN_INTERVAL = 1'b1;

   // Item codes.
   localparam logic OP_TRIGGER = 1'b0;
   localparam logic OP_FRAME   = 1'b1;

   typedef struct packed {
      logic              op;
      logic [CH_W-1:0]   channel;
      logic [TYPE_W-1:0] alarm_type;
      logic [TS_W-1:0]   timestamp_us;
   } req_item_type;

   typedef struct packed {
      logic              accepted;
      logic              start_capture;
      logic              save_frame;
      logic [TYPE_W-1:0] saved_type;
      logic              burst_done;
      logic [SPAN_W-1:0] burst_span_s;
   } rsp_item_type;

   // Item after classification, as it waits in the queue.
   typedef struct packed {
      logic              op;
      logic              in_range;
      logic [CH_W-1:0]   channel;
      logic [TYPE_W-1:0] alarm_type;
      logic [TS_W-1:0]   timestamp_us;
   } work_type;

   typedef struct packed {
      logic     valid;
      work_type item;
   } front_out_type;

   typedef struct packed {
      logic [COUNT_W-1:0] burst_count;
      logic [THR_W-1:0]   thr_us;
      logic [SPAN_W-1:0]  span_s;
   } cfg_type;

   // One channel record as held in the channel RAM.
   typedef struct packed {
      logic               active;
      logic [COUNT_W-1:0] kept_count;
      logic [TS_W-1:0]    last_time;
      logic [TYPE_W-1:0]  alarm_type;
   } chan_entry_type;

   localparam int ENTRY_W = $bits(chan_entry_type);

endpackage

@@ rtl/asbg_ram.sv @@
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module asbg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/asbg_front.sv @@
// ----------------------------------------------------------------------------
// Alarm snapshot gate front end
// Accepts items, checks the channel range and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module asbg_front #(
   parameter int CHANNELS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  asbg_pkg::req_item_type req_item,
   output logic                   busy,
   output asbg_pkg::front_out_type head,
   input  logic                   pop
);
   import asbg_pkg::*;

   localparam logic [8:0] CHAN_LIMIT = 9'(CHANNELS);

   work_type   q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   work_type   work;

   always_comb begin
      work.op           = req_item.op;
      work.in_range     = ({4'b0, req_item.channel} < CHAN_LIMIT);
      work.channel      = req_item.channel;
      work.alarm_type   = req_item.alarm_type;
      work.timestamp_us = req_item.timestamp_us;
   end

   assign busy = (count_ff == 2'd2);
   assign push = start && !busy;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         q_ff[wr_ptr_ff] <= work;
      end
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.item  = q_ff[rd_ptr_ff];

endmodule

@@ rtl/asbg_back.sv @@
// ----------------------------------------------------------------------------
// Alarm snapshot gate back end
// Read-modify-write of one channel record per item and result generation.
// ----------------------------------------------------------------------------
module asbg_back #(
   parameter int CHANNELS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  asbg_pkg::front_out_type head,
   output logic                    pop,
   input  asbg_pkg::cfg_type       cfg,
   output logic                    rsp_strobe,
   output asbg_pkg::rsp_item_type  rsp_item
);
   import asbg_pkg::*;

   localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type          state_ff, state_in;
   work_type           cur_ff, cur_in;
   logic               ent_vld_ff, ent_vld_in;
   logic [COUNT_W-1:0] target_ff, target_in;
   logic [CHANNELS-1:0] valid_ff, valid_in;
   rsp_item_type       rsp_ff, rsp_in;
   logic               strobe_ff, strobe_in;

   logic [IDX_W-1:0]   rd_addr, wr_addr;
   logic [CH_W+IDX_W-1:0] rd_wide, wr_wide;
   logic [ENTRY_W-1:0] rd_data;
   logic               wr_en;
   chan_entry_type     ent, ent_new;
   logic [TS_W:0]      diff;
   logic               keep;
   logic [COUNT_W-1:0] kc;

   assign rd_wide = {{IDX_W{1'b0}}, head.item.channel};
   assign rd_addr = rd_wide[IDX_W-1:0];
   assign wr_wide = {{IDX_W{1'b0}}, cur_ff.channel};
   assign wr_addr = wr_wide[IDX_W-1:0];

   assign pop = (state_ff == ST_IDLE) && head.valid;

   asbg_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CHANNELS)
   ) u_chan_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (ent_new),
      .rd_en   (pop),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A record never written since reset reads as all zero.
   assign ent = ent_vld_ff ? chan_entry_type'(rd_data) : '0;

   // Whole seconds elapsed >= interval is the same as elapsed us >= interval * 1e6.
   assign diff = {1'b0, cur_ff.timestamp_us} - {1'b0, ent.last_time};
   assign keep = diff[TS_W] || (diff == '0) || (diff[TS_W-1:0] >= TS_W'(cfg.thr_us));

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      ent_vld_in = ent_vld_ff;
      target_in  = target_ff;
      valid_in   = valid_ff;
      rsp_in     = rsp_ff;
      strobe_in  = 1'b0;
      wr_en      = 1'b0;
      ent_new    = ent;
      kc         = ent.kept_count;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               cur_in     = head.item;
               ent_vld_in = head.item.in_range && valid_ff[rd_addr];
               state_in   = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_in               = '0;
            rsp_in.accepted      = 1'b1;
            rsp_in.burst_span_s  = cfg.span_s;
            strobe_in            = 1'b1;
            state_in             = ST_IDLE;
            if (cur_ff.op == OP_TRIGGER) begin
               if (cfg.burst_count == '0) begin
                  rsp_in.accepted = 1'b0;
               end else if (cur_ff.in_range && ent.alarm_type == '0) begin
                  ent_new.alarm_type = cur_ff.alarm_type;
                  if (!ent.active) begin
                     ent_new.active = 1'b1;
                     target_in      = cfg.burst_count;
                  end
                  rsp_in.start_capture = 1'b1;
                  wr_en                = 1'b1;
               end
            end else if (cur_ff.in_range && ent.active) begin
               if (ent.kept_count < target_ff && keep) begin
                  kc                   = ent.kept_count + COUNT_W'(1);
                  ent_new.kept_count   = kc;
                  ent_new.last_time    = cur_ff.timestamp_us;
                  rsp_in.save_frame    = 1'b1;
                  rsp_in.saved_type    = ent.alarm_type;
                  wr_en                = 1'b1;
               end
               if (kc >= target_ff) begin
                  ent_new           = '0;
                  rsp_in.burst_done = 1'b1;
                  wr_en             = 1'b1;
               end
            end
            if (wr_en) begin
               valid_in[wr_addr] = 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         target_ff  <= '0;
         valid_ff   <= '0;
         strobe_ff  <= 1'b0;
         ent_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         target_ff  <= target_in;
         valid_ff   <= valid_in;
         strobe_ff  <= strobe_in;
         ent_vld_ff <= ent_vld_in;
      end
      cur_ff <= cur_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ rtl/alarm_snapshot_burst_gate_unit.sv @@
// ----------------------------------------------------------------------------
// Alarm snapshot burst gate
// Decides per channel which video frames are kept as alarm snapshots.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only while
// the two-entry input queue is full. Each item yields exactly one result, shown
// for one cycle with rsp_strobe, and the receiver cannot hold it off. The back
// end does a read-modify-write of one channel record in the channel RAM, so it
// takes no new item before it is through with the last one. An item passes
// from the input queue to the idle state, which reads its channel record, and
// the exec state, which writes the record back and registers the result.
// Channel records are cleared at reset through per-channel valid bits, so no
// clearing pass is needed. Writes reach the interval threshold and burst span
// through the configuration registers and then the thr and span registers.
module alarm_snapshot_burst_gate_unit #(
   parameter int CHANNELS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  asbg_pkg::req_item_type req_item,
   output logic                   busy,
   output logic                   rsp_strobe,
   output asbg_pkg::rsp_item_type rsp_item,
   input  logic                   csr_we,
   input  logic                   csr_index,
   input  logic [15:0]            csr_wdata
);
   import asbg_pkg::*;

   logic [COUNT_W-1:0]       burst_count_ff;
   logic [IVAL_W-1:0]        interval_ff;
   logic [THR_W-1:0]         thr_ff, thr_in;
   logic [SPAN_W-1:0]        span_ff, span_in;
   logic [COUNT_W+IVAL_W-1:0] prod;
   front_out_type            head;
   logic                     pop;
   cfg_type                  cfg;

   always_ff @(posedge clock) begin
      if (reset) begin
         burst_count_ff <= RESET_BURST;
         interval_ff    <= RESET_INTERVAL;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BURST_COUNT:  burst_count_ff <= csr_wdata[COUNT_W-1:0];
            CSR_MIN_INTERVAL: interval_ff    <= csr_wdata[IVAL_W-1:0];
            default: ;
         endcase
      end
      thr_ff  <= thr_in;
      span_ff <= span_in;
   end

   always_comb begin
      thr_in  = THR_W'(interval_ff) * THR_W'(US_PER_S);
      prod    = (COUNT_W+IVAL_W)'(interval_ff) * (COUNT_W+IVAL_W)'(burst_count_ff);
      span_in = (prod > (COUNT_W+IVAL_W)'(SPAN_CAP)) ? SPAN_CAP : prod[SPAN_W-1:0];
   end

   assign cfg.burst_count = burst_count_ff;
   assign cfg.thr_us      = thr_ff;
   assign cfg.span_s      = span_ff;

   asbg_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .head     (head),
      .pop      (pop)
   );

   asbg_back #(
      .CHANNELS (CHANNELS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .pop        (pop),
      .cfg        (cfg),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

`ifndef SYNTH
   // The back end finishes one item before it takes the next, so results never strobe back to back.
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("results strobed in back-to-back cycles");

   a_trigger_frame_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.start_capture |->
         !rsp_item.save_frame && !rsp_item.burst_done && rsp_item.accepted)
      else $error("trigger and frame flags mixed in one result");

   a_saved_type: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.saved_type != '0) |-> rsp_item.save_frame)
      else $error("saved type reported without a saved frame");

   a_span_cap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.burst_span_s <= SPAN_CAP))
      else $error("burst span above its cap");
`endif

endmodule
